### rtl/core/ordered_list_insert_remove_find_assert.svh
// Assertion macros used by the checker file of the ordered list block.
`ifndef ORDERED_LIST_INSERT_REMOVE_FIND_ASSERT_SVH
`define ORDERED_LIST_INSERT_REMOVE_FIND_ASSERT_SVH

// Clocked assertion, switched off while reset is held.
`define OLIF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define OLIF_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/olif_pkg.sv
// Package: widths, codes and state type of the ordered list block.
`timescale 1ns / 1ps
package olif_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int WIDTH_DEF = 32;

  localparam int OP_W  = 2;
  localparam int POS_W = 5;
  localparam int VAL_W = 32;
  localparam int STS_W = 2;
  localparam int LEN_W = 5;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_APPEND = 2'd1,
    OP_REMOVE = 2'd2,
    OP_FIND   = 2'd3
  } olif_op_t;

  typedef enum logic [STS_W-1:0] {
    ST_OK       = 2'd0,
    ST_BEYOND   = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } olif_status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHUP,
    S_SHDN,
    S_PUT,
    S_RESP
  } olif_state_t;

endpackage

### rtl/core/olif_if.sv
// Channel interfaces: operation requests in, results out.
`timescale 1ns / 1ps
interface olif_req_if;
  import olif_pkg::*;
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  operation;
  logic [POS_W-1:0] position;
  logic [VAL_W-1:0] value;

  modport source (output valid, output operation, output position, output value,
                  input ready);
  modport sink   (input valid, input operation, input position, input value,
                  output ready);
endinterface

interface olif_rsp_if;
  import olif_pkg::*;
  logic             valid;
  logic             ready;
  logic             success;
  logic [STS_W-1:0] status;
  logic [LEN_W-1:0] length;

  modport source (output valid, output success, output status, output length,
                  input ready);
  modport sink   (input valid, input success, input status, input length,
                  output ready);
endinterface

### rtl/core/olif_ram.sv
// Generic single write port RAM with one registered read port.
`timescale 1ns / 1ps
module olif_ram #(
  parameter int W = 32,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/ordered_list_insert_remove_find.sv
// Top level: bounded ordered list with shift insert, shift remove and find.
//
//   channel   dir   handshake      payload
//   in_req    in    valid/ready    operation, position, value
//   out_rsp   out   valid/ready    success, status, length
//
// One operation at a time; the entries sit in one RAM with a single read
// and a single write port, one entry moved or compared per cycle.
// Insert at p shifts entries n - 1 down to p up by one, then writes p; append
// writes n directly. Find scans up from 0; remove shifts later entries down.
// Reset clears the state, the count, the pending flag and the result valid only; no clearing pass.
// A result waits in its register while the next operation runs.
`timescale 1ns / 1ps
module ordered_list_insert_remove_find #(
  parameter int DEPTH = olif_pkg::DEPTH_DEF,
  parameter int WIDTH = olif_pkg::WIDTH_DEF
) (
  input logic clk,
  input logic rst_n,
  olif_req_if.sink   in_req,
  olif_rsp_if.source out_rsp
);
  import olif_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = (CW > POS_W) ? CW : POS_W;
  localparam int VW = (WIDTH < VAL_W) ? WIDTH : VAL_W;

  olif_state_t  state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [AW-1:0] tgt_r, tgt_nxt;
  logic          pend_r, pend_nxt;
  logic [AW-1:0] pend_addr_r, pend_addr_nxt;
  olif_op_t      op_r, op_nxt;
  logic [WIDTH-1:0] val_r, val_nxt;
  olif_status_t  sts_r, sts_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic             out_success_r, out_success_nxt;
  olif_status_t     out_status_r, out_status_nxt;
  logic [LEN_W-1:0] out_length_r, out_length_nxt;

  logic             we;
  logic [AW-1:0]    waddr;
  logic [WIDTH-1:0] wdata;
  logic [AW-1:0]    raddr;
  logic [WIDTH-1:0] rdata;

  logic          in_acc;
  olif_op_t      in_op;
  logic [PW-1:0] pos_ext;
  logic [PW-1:0] cnt_ext;
  logic [PW-1:0] tgt_ext;
  logic          match;

  olif_ram #(.W(WIDTH), .D(DEPTH)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign in_req.ready    = (state_r == S_IDLE);
  assign in_acc          = in_req.valid && in_req.ready;
  assign in_op           = olif_op_t'(in_req.operation);
  assign pos_ext         = PW'(in_req.position);
  assign cnt_ext         = PW'(count_r);
  assign tgt_ext         = (in_op == OP_APPEND) ? cnt_ext : pos_ext;
  assign match           = pend_r && (rdata == val_r);

  assign out_rsp.valid   = out_valid_r;
  assign out_rsp.success = out_success_r;
  assign out_rsp.status  = out_status_r;
  assign out_rsp.length  = out_length_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r         <= idx_nxt;
    tgt_r         <= tgt_nxt;
    pend_addr_r   <= pend_addr_nxt;
    op_r          <= op_nxt;
    val_r         <= val_nxt;
    sts_r         <= sts_nxt;
    out_success_r <= out_success_nxt;
    out_status_r  <= out_status_nxt;
    out_length_r  <= out_length_nxt;
  end

  always_comb begin
    state_nxt       = state_r;
    count_nxt       = count_r;
    idx_nxt         = idx_r;
    tgt_nxt         = tgt_r;
    pend_nxt        = pend_r;
    pend_addr_nxt   = pend_addr_r;
    op_nxt          = op_r;
    val_nxt         = val_r;
    sts_nxt         = sts_r;
    out_valid_nxt   = out_valid_r;
    out_success_nxt = out_success_r;
    out_status_nxt  = out_status_r;
    out_length_nxt  = out_length_r;
    we              = 1'b0;
    waddr           = pend_addr_r;
    wdata           = rdata;
    raddr           = idx_r[AW-1:0];

    // drop the result once the sink has taken it
    if (out_valid_r && out_rsp.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          op_nxt   = in_op;
          val_nxt  = WIDTH'(in_req.value[VW-1:0]);
          pend_nxt = 1'b0;
          case (in_op)
            OP_INSERT, OP_APPEND: begin
              if (tgt_ext > cnt_ext) begin
                sts_nxt   = ST_BEYOND;
                state_nxt = S_RESP;
              end else if (count_r == CW'(DEPTH)) begin
                sts_nxt   = ST_FULL;
                state_nxt = S_RESP;
              end else begin
                tgt_nxt = tgt_ext[AW-1:0];
                if (tgt_ext == cnt_ext) begin
                  state_nxt = S_PUT;
                end else begin
                  idx_nxt   = count_r - 1'b1;
                  state_nxt = S_SHUP;
                end
              end
            end
            default: begin
              idx_nxt   = '0;
              state_nxt = S_SCAN;
            end
          endcase
        end
      end

      S_SCAN: begin
        if (match) begin
          pend_nxt = 1'b0;
          if (op_r == OP_FIND) begin
            sts_nxt   = ST_OK;
            state_nxt = S_RESP;
          end else begin
            idx_nxt   = CW'(pend_addr_r) + 1'b1;
            state_nxt = S_SHDN;
          end
        end else if (idx_r < count_r) begin
          pend_nxt      = 1'b1;
          pend_addr_nxt = idx_r[AW-1:0];
          idx_nxt       = idx_r + 1'b1;
        end else begin
          pend_nxt  = 1'b0;
          sts_nxt   = ST_NOTFOUND;
          state_nxt = S_RESP;
        end
      end

      S_SHUP: begin
        // move the word read last cycle up by one while reading the next lower
        if (pend_r) begin
          we    = 1'b1;
          waddr = pend_addr_r + 1'b1;
        end
        pend_nxt      = 1'b1;
        pend_addr_nxt = idx_r[AW-1:0];
        if (idx_r[AW-1:0] == tgt_r) begin
          state_nxt = S_PUT;
        end else begin
          idx_nxt = idx_r - 1'b1;
        end
      end

      S_PUT: begin
        if (pend_r) begin
          we       = 1'b1;
          waddr    = pend_addr_r + 1'b1;
          pend_nxt = 1'b0;
        end else begin
          we        = 1'b1;
          waddr     = tgt_r;
          wdata     = val_r;
          count_nxt = count_r + 1'b1;
          sts_nxt   = ST_OK;
          state_nxt = S_RESP;
        end
      end

      S_SHDN: begin
        // move the word read last cycle down by one while reading the next higher
        if (pend_r) begin
          we       = 1'b1;
          waddr    = pend_addr_r - 1'b1;
          pend_nxt = 1'b0;
        end
        if (idx_r < count_r) begin
          pend_nxt      = 1'b1;
          pend_addr_nxt = idx_r[AW-1:0];
          idx_nxt       = idx_r + 1'b1;
        end else begin
          count_nxt = count_r - 1'b1;
          sts_nxt   = ST_OK;
          state_nxt = S_RESP;
        end
      end

      S_RESP: begin
        // hold until the result register is free
        if (!out_valid_r || out_rsp.ready) begin
          out_valid_nxt   = 1'b1;
          out_success_nxt = (sts_r == ST_OK);
          out_status_nxt  = sts_r;
          out_length_nxt  = LEN_W'(count_r);
          state_nxt       = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

### rtl/core/olif_chk.sv
// Port checker for the ordered list block, bound to the top level.
`timescale 1ns / 1ps
`include "ordered_list_insert_remove_find_assert.svh"
module olif_chk (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic                     out_success,
  input logic [olif_pkg::STS_W-1:0] out_status,
  input logic [olif_pkg::LEN_W-1:0] out_length
);
  import olif_pkg::*;

  // a stalled result keeps its fields
  `OLIF_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_success) && $stable(out_status) && $stable(out_length), "stalled result changed")

  // reset empties the result register
  `OLIF_ASSERT_RST(a_rst_clear, !rst_n |=> !out_valid, "result valid after reset")

  // one operation at a time: busy right after an accepted transaction
  `OLIF_ASSERT(a_in_busy, in_valid && in_ready |=> !in_ready, "second transaction taken while busy")

  // no result can appear in the cycle after a request when none was waiting
  `OLIF_ASSERT(a_no_early, in_valid && in_ready && !out_valid |=> !out_valid, "result too early")

endmodule

bind ordered_list_insert_remove_find olif_chk u_olif_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_req.valid),
  .in_ready    (in_req.ready),
  .out_valid   (out_rsp.valid),
  .out_ready   (out_rsp.ready),
  .out_success (out_rsp.success),
  .out_status  (out_rsp.status),
  .out_length  (out_rsp.length)
);

### tb/ordered_list_insert_remove_find_tb.sv
// Testbench: ordered list block driven with directed and random operations, checked by a predictor.
`timescale 1ns / 1ps
module ordered_list_insert_remove_find_tb;
  import olif_pkg::*;

  localparam int CLK_HALF       = 6;
  localparam int RESET_CYCLES   = 5;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 200;
  localparam int SETTLE_CYCLES  = 60;

  typedef struct {
    logic             success;
    olif_status_t     status;
    logic [LEN_W-1:0] length;
  } list_result_t;

  logic clk;
  logic rst_n;

  olif_req_if req_ch ();
  olif_rsp_if rsp_ch ();

  ordered_list_insert_remove_find u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_ch),
    .out_rsp (rsp_ch)
  );

  // Predicted list contents and length
  logic [VAL_W-1:0] list_words [DEPTH_DEF];
  int               list_len = 0;
  list_result_t     pending_results [$];
  list_result_t     oldest_result;

  logic [VAL_W-1:0] value_pool [8];
  int               target_len = 0;
  int               err_count  = 0;
  int               idle_cycles;
  bit               idle_en = 1'b1;
  int               hold_ask = 0;
  int               hold_seen;
  int               hold_left;
  int               stall_left;

  always begin
    clk = 1'b0;
    #CLK_HALF;
    clk = 1'b1;
    #CLK_HALF;
  end

  function automatic list_result_t apply_list_op(olif_op_t op, logic [POS_W-1:0] pos,
                                                 logic [VAL_W-1:0] val);
    list_result_t res;
    olif_status_t st;
    int           hit;
    int           where;
    st  = ST_OK;
    hit = -1;
    for (int i = 0; i < list_len; i++) begin
      if (hit < 0 && list_words[i] == val) hit = i;
    end
    case (op)
      OP_INSERT, OP_APPEND: begin
        where = (op == OP_APPEND) ? list_len : int'(pos);
        if (where > list_len) st = ST_BEYOND;
        else if (list_len >= DEPTH_DEF) st = ST_FULL;
        else begin
          for (int i = list_len; i > where; i--) list_words[i] = list_words[i-1];
          list_words[where] = val;
          list_len++;
        end
      end
      OP_REMOVE: begin
        if (hit < 0) st = ST_NOTFOUND;
        else begin
          for (int i = hit; i + 1 < list_len; i++) list_words[i] = list_words[i+1];
          list_len--;
        end
      end
      default: begin
        if (hit < 0) st = ST_NOTFOUND;
      end
    endcase
    res.success = (st == ST_OK);
    res.status  = st;
    res.length  = list_len[LEN_W-1:0];
    return res;
  endfunction

  // Offer one transaction, with an occasional random gap ahead of it; hold valid high afterwards
  task automatic send_op(olif_op_t op, logic [POS_W-1:0] pos, logic [VAL_W-1:0] val);
    int gap;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 5);
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.operation <= op;
    req_ch.position  <= pos;
    req_ch.value     <= val;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    pending_results.insert(pending_results.size(), apply_list_op(op, pos, val));
  endtask

  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [VAL_W-1:0] pick_value(bit from_list);
    int roll;
    roll = $urandom_range(0, 99);
    if (from_list && list_len > 0 && roll < 45) return list_words[$urandom_range(0, list_len - 1)];
    if (roll < 75) return value_pool[$urandom_range(0, 7)];
    return $urandom;
  endfunction

  task automatic send_random_op();
    int               roll;
    olif_op_t         op;
    logic [POS_W-1:0] pos;
    roll = $urandom_range(0, 99);
    // steer the length towards the current target so both empty and full get visited
    if (list_len < target_len)
      op = roll < 40 ? OP_INSERT : roll < 65 ? OP_APPEND : roll < 80 ? OP_FIND : OP_REMOVE;
    else
      op = roll < 15 ? OP_INSERT : roll < 25 ? OP_APPEND : roll < 60 ? OP_FIND : OP_REMOVE;
    if (op == OP_INSERT && $urandom_range(0, 99) < 85) pos = POS_W'($urandom_range(0, list_len));
    else pos = POS_W'($urandom_range(0, DEPTH_DEF));
    send_op(op, pos, pick_value(op == OP_REMOVE || op == OP_FIND));
  endtask

  task automatic test_empty_list();
    send_op(OP_FIND, 5'd0, 32'h0000_0000);
    send_op(OP_REMOVE, 5'd16, 32'hFFFF_FFFF);
    send_op(OP_INSERT, 5'd1, 32'h0000_0001);
  endtask

  task automatic test_insert_positions();
    send_op(OP_INSERT, 5'd0, 32'h0000_0000);
    send_op(OP_APPEND, 5'd31, 32'hFFFF_FFFF);
    send_op(OP_INSERT, 5'd1, 32'h5A5A_5A5A);
    send_op(OP_INSERT, 5'd3, 32'h8000_0000);
    send_op(OP_INSERT, 5'd0, 32'h0000_0001);
  endtask

  task automatic test_duplicates();
    send_op(OP_APPEND, 5'd0, 32'h0000_0000);
    send_op(OP_REMOVE, 5'd0, 32'h0000_0000);
    send_op(OP_FIND, 5'd0, 32'h0000_0000);
  endtask

  task automatic test_full_list();
    while (list_len < DEPTH_DEF) begin
      if (list_len % 2 == 0) send_op(OP_INSERT, POS_W'($urandom_range(0, list_len)), $urandom);
      else send_op(OP_APPEND, 5'd0, $urandom);
    end
    send_op(OP_APPEND, 5'd0, 32'hA5A5_A5A5);
    send_op(OP_INSERT, 5'd16, 32'h0000_0002);
    send_op(OP_FIND, 5'd0, list_words[DEPTH_DEF-1]);
  endtask

  task automatic test_random_mix(int n_items);
    for (int i = 0; i < n_items; i++) begin
      if (i % 30 == 0) begin
        case ($urandom_range(0, 3))
          0:       target_len = 0;
          1:       target_len = DEPTH_DEF;
          default: target_len = $urandom_range(0, DEPTH_DEF);
        endcase
      end
      send_random_op();
    end
  endtask

  task automatic test_output_hold_off();
    hold_ask++;
    test_random_mix(20);
  endtask

  task automatic test_drain_pause();
    test_random_mix(15);
    wait_drained();
    test_random_mix(15);
  endtask

  function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d got %0d", $time, field, want, got);
      err_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result expected none got success=%0b status=%0d length=%0d",
                 $time, rsp_ch.success, rsp_ch.status, rsp_ch.length);
        err_count++;
      end else begin
        oldest_result = pending_results.pop_front();
        check_field("success", oldest_result.success, rsp_ch.success);
        check_field("status", oldest_result.status, rsp_ch.status);
        check_field("length", oldest_result.length, rsp_ch.length);
      end
    end
  end

  // Result side: random short stalls, plus a long hold-off when asked
  always @(posedge clk) begin
    if (!rst_n) begin
      rsp_ch.ready <= 1'b0;
      hold_seen    <= 0;
      hold_left    <= 0;
      stall_left   <= 0;
    end else if (hold_seen != hold_ask) begin
      hold_seen    <= hold_ask;
      hold_left    <= HOLD_CYCLES - 1;
      rsp_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      rsp_ch.ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left   <= stall_left - 1;
      rsp_ch.ready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 4) == 0) begin
      stall_left   <= $urandom_range(0, 4);
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("ordered_list_insert_remove_find: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_n            <= 1'b0;
    req_ch.valid     <= 1'b0;
    req_ch.operation <= OP_FIND;
    req_ch.position  <= '0;
    req_ch.value     <= '0;
    value_pool[0] = 32'h0000_0000;
    value_pool[1] = 32'hFFFF_FFFF;
    value_pool[2] = 32'h8000_0000;
    value_pool[3] = 32'h0000_0001;
    for (int i = 4; i < 8; i++) value_pool[i] = $urandom;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_list();
    test_insert_positions();
    test_duplicates();
    test_full_list();
    test_random_mix(290);
    test_output_hold_off();
    test_drain_pause();
    idle_en = 1'b0;
    test_random_mix(200);

    wait_drained();
    if (err_count == 0 && pending_results.size() == 0) begin
      $display("ordered_list_insert_remove_find: match");
    end else begin
      $display("ordered_list_insert_remove_find: mismatch");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/olif_pkg.sv
rtl/core/olif_if.sv
rtl/core/olif_ram.sv
rtl/core/ordered_list_insert_remove_find.sv
rtl/core/olif_chk.sv
tb/ordered_list_insert_remove_find_tb.sv
